/* sv/cmap_pkg.sv */
`default_nettype none

package cmap_pkg;

    // Color scheme codes held in the scheme register.
    localparam logic [2:0] SCHEME_GRAY   = 3'd0;
    localparam logic [2:0] SCHEME_HOT    = 3'd1;
    localparam logic [2:0] SCHEME_JET    = 3'd2;
    localparam logic [2:0] SCHEME_COLD   = 3'd3;
    localparam logic [2:0] SCHEME_BLUE   = 3'd4;
    localparam logic [2:0] SCHEME_CYCLIC = 3'd5;
    localparam logic [2:0] SCHEME_SIGNED = 3'd6;
    localparam logic [2:0] SCHEME_BLACK  = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] REG_SCHEME   = 3'd0;
    localparam logic [2:0] REG_LOW      = 3'd1;
    localparam logic [2:0] REG_HIGH     = 3'd2;
    localparam logic [2:0] REG_INV_SPAN = 3'd3;
    localparam logic [2:0] REG_INV_POS  = 3'd4;
    localparam logic [2:0] REG_INV_NEG  = 3'd5;

    // Fixed colors chosen by the range checks or the black scheme instead of the scheme curve.
    localparam logic [2:0] FORCE_NONE  = 3'd0;
    localparam logic [2:0] FORCE_BLACK = 3'd1;
    localparam logic [2:0] FORCE_WHITE = 3'd2;
    localparam logic [2:0] FORCE_RED   = 3'd3;
    localparam logic [2:0] FORCE_BLUE  = 3'd4;

    // Levels are Q.16 with 1.0 at 65536.
    localparam logic [16:0] LEVEL_ONE  = 17'd65536;
    localparam logic [16:0] LEVEL_HALF = 17'd32768;
    localparam logic [16:0] LEVEL_MAX  = 17'd65535;
    localparam logic [16:0] LEVEL_075  = 17'd49152;
    localparam logic [15:0] JET_BASE   = 16'd35389;
    localparam logic [14:0] JET_GAIN   = 15'd30147;

    // Reset values of the configuration registers.
    localparam logic [31:0] RESET_LOW  = 32'd0;
    localparam logic [31:0] RESET_HIGH = 32'd65536;
    localparam logic [31:0] RESET_INV  = 32'd16777216;

    typedef struct packed {
        logic [2:0]  scheme;
        logic [31:0] low_bound;
        logic [31:0] high_bound;
        logic [31:0] inv_span;
        logic [31:0] inv_positive;
        logic [31:0] inv_negative;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  scheme;
        logic [2:0]  force_kind;
        logic        s_pos;
        logic [7:0]  wrap_fix;
        logic [31:0] mul_a;
        logic [31:0] mul_b;
    } front_t;

    typedef struct packed {
        logic [2:0]  scheme;
        logic [2:0]  force_kind;
        logic        s_pos;
        logic [7:0]  wrap_fix;
        logic [63:0] product;
    } prod_t;

    typedef struct packed {
        logic [2:0]  scheme;
        logic [2:0]  force_kind;
        logic        s_pos;
        logic [16:0] t;
    } norm_t;

    typedef struct packed {
        logic [16:0] r;
        logic [16:0] g;
        logic [16:0] b;
    } level_t;

    // Scale a Q.16 level to an 8-bit channel with rounding: (x*255 + 0.5) >> 16.
    function automatic logic [7:0] chan_scale(input logic [16:0] level);
        logic [16:0] clamped;
        logic [24:0] scaled;
        clamped = (level > LEVEL_ONE) ? LEVEL_ONE : level;
        scaled  = {clamped, 8'h00} - {8'h00, clamped} + 25'd32768;
        return scaled[23:16];
    endfunction

endpackage

`default_nettype wire

/* sv/cmap_front.sv */
`default_nettype none

module cmap_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [31:0]  sample_value,
    input  wire cmap_pkg::cfg_t      cfg,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cmap_pkg::front_t         out_data
);

    logic               valid_reg;
    cmap_pkg::front_t   data_reg;
    cmap_pkg::front_t   data_next;
    logic signed [32:0] v;
    logic               below;
    logic               at_or_above;
    logic               above;
    logic               s_pos;

    // Offset from the range minimum and the range checks.
    assign v           = {sample_value[31], sample_value}
                         - {cfg.low_bound[31], cfg.low_bound};
    assign below       = v[32];
    assign at_or_above = sample_value >= $signed(cfg.high_bound);
    assign above       = sample_value > $signed(cfg.high_bound);
    assign s_pos       = !sample_value[31] && (sample_value != 32'sd0);

    // Pick the multiplier operands and the fixed color, if any.
    always_comb
    begin
        data_next.scheme     = cfg.scheme;
        data_next.s_pos      = s_pos;
        data_next.wrap_fix   = below ? (8'h00 - cfg.inv_span[7:0]) : 8'h00;
        data_next.mul_a      = v[31:0];
        data_next.mul_b      = cfg.inv_span;
        data_next.force_kind = cmap_pkg::FORCE_NONE;
        unique case (cfg.scheme)
            cmap_pkg::SCHEME_BLACK:
            begin
                data_next.force_kind = cmap_pkg::FORCE_BLACK;
            end
            cmap_pkg::SCHEME_SIGNED:
            begin
                if (s_pos)
                begin
                    data_next.mul_a = sample_value;
                    data_next.mul_b = cfg.inv_positive;
                    if (above)
                    begin
                        data_next.force_kind = cmap_pkg::FORCE_WHITE;
                    end
                end
                else
                begin
                    data_next.mul_b = cfg.inv_negative;
                    if (below)
                    begin
                        data_next.force_kind = cmap_pkg::FORCE_BLACK;
                    end
                end
            end
            cmap_pkg::SCHEME_CYCLIC:
            begin
                data_next.force_kind = cmap_pkg::FORCE_NONE;
            end
            default:
            begin
                if (below)
                begin
                    data_next.force_kind = cmap_pkg::FORCE_BLACK;
                end
                else if (at_or_above)
                begin
                    if (cfg.scheme == cmap_pkg::SCHEME_JET)
                    begin
                        data_next.force_kind = cmap_pkg::FORCE_RED;
                    end
                    else if (cfg.scheme == cmap_pkg::SCHEME_BLUE)
                    begin
                        data_next.force_kind = cmap_pkg::FORCE_BLUE;
                    end
                    else
                    begin
                        data_next.force_kind = cmap_pkg::FORCE_WHITE;
                    end
                end
            end
        endcase
    end

    // Stage register; it loads whenever its slot is free or drains.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cmap_mult.sv */
`default_nettype none

module cmap_mult (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cmap_pkg::front_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cmap_pkg::prod_t        out_data
);

    logic             valid_reg;
    cmap_pkg::prod_t  data_reg;
    cmap_pkg::prod_t  data_next;

    // One 32 by 32 unsigned product, offset or sample by reciprocal.
    always_comb
    begin
        data_next.scheme     = in_data.scheme;
        data_next.force_kind = in_data.force_kind;
        data_next.s_pos      = in_data.s_pos;
        data_next.wrap_fix   = in_data.wrap_fix;
        data_next.product    = {32'h0, in_data.mul_a} * {32'h0, in_data.mul_b};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cmap_norm.sv */
`default_nettype none

module cmap_norm (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cmap_pkg::prod_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cmap_pkg::norm_t       out_data
);

    logic             valid_reg;
    cmap_pkg::norm_t  data_reg;
    cmap_pkg::norm_t  data_next;
    logic [39:0]      p40;
    logic [15:0]      wrapped;

    // The position is the product shifted down by 24 bits. The cyclic map keeps
    // only the fraction of a 40-bit product, with the sign of a negative offset
    // folded in through the wrap correction.
    assign p40     = in_data.product[63:24];
    assign wrapped = in_data.product[39:24] + {in_data.wrap_fix, 8'h00};

    always_comb
    begin
        data_next.scheme     = in_data.scheme;
        data_next.force_kind = in_data.force_kind;
        data_next.s_pos      = in_data.s_pos;
        unique case (in_data.scheme)
            cmap_pkg::SCHEME_CYCLIC:
            begin
                data_next.t = {1'b0, wrapped};
            end
            cmap_pkg::SCHEME_SIGNED:
            begin
                data_next.t = (p40 > 40'd65536) ? cmap_pkg::LEVEL_ONE : p40[16:0];
            end
            default:
            begin
                data_next.t = (p40 > 40'd65535) ? cmap_pkg::LEVEL_MAX : p40[16:0];
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cmap_level.sv */
`default_nettype none

module cmap_level (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cmap_pkg::norm_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cmap_pkg::level_t      out_data
);

    logic              valid_reg;
    cmap_pkg::level_t  data_reg;
    cmap_pkg::level_t  data_next;
    logic [17:0]       t3;
    logic [1:0]        seg3;
    logic [16:0]       f3;
    logic [16:0]       inv_f3;
    logic [1:0]        seg4;
    logic [16:0]       f4;
    logic [16:0]       inv_f4;
    logic [31:0]       jet_prod;
    logic [16:0]       jet_low;
    logic [17:0]       twice_t;
    logic [16:0]       signed_b;
    logic [16:0]       signed_r;
    logic [16:0]       t;

    assign t = in_data.t;

    // Thirds and quarters of the position, each with its fraction.
    assign t3     = {2'b00, t[15:0]} + {1'b0, t[15:0], 1'b0};
    assign seg3   = t3[17:16];
    assign f3     = {1'b0, t3[15:0]};
    assign inv_f3 = cmap_pkg::LEVEL_ONE - f3;
    assign seg4   = t[15:14];
    assign f4     = {1'b0, t[13:0], 2'b00};
    assign inv_f4 = cmap_pkg::LEVEL_ONE - f4;

    // Lowest jet quarter ramps blue from 0.54 to 1.0.
    assign jet_prod = {17'h0, cmap_pkg::JET_GAIN} * {15'h0, f4} + 32'd32768;
    assign jet_low  = {1'b0, cmap_pkg::JET_BASE} + {1'b0, jet_prod[31:16]};

    // Two-sided map: blue rises over the upper half, red starts at 0.75.
    assign twice_t  = {t, 1'b0};
    assign signed_b = (t > cmap_pkg::LEVEL_HALF) ? 17'(twice_t - 18'd65536) : 17'd0;
    assign signed_r = cmap_pkg::LEVEL_075 + {2'b00, t[16:2]};

    always_comb
    begin
        data_next.r = 17'd0;
        data_next.g = 17'd0;
        data_next.b = 17'd0;
        if (in_data.force_kind != cmap_pkg::FORCE_NONE)
        begin
            unique case (in_data.force_kind)
                cmap_pkg::FORCE_WHITE:
                begin
                    data_next.r = cmap_pkg::LEVEL_ONE;
                    data_next.g = cmap_pkg::LEVEL_ONE;
                    data_next.b = cmap_pkg::LEVEL_ONE;
                end
                cmap_pkg::FORCE_RED:
                begin
                    data_next.r = cmap_pkg::LEVEL_ONE;
                end
                cmap_pkg::FORCE_BLUE:
                begin
                    data_next.b = cmap_pkg::LEVEL_ONE;
                end
                default:
                begin
                    data_next.r = 17'd0;
                end
            endcase
        end
        else
        begin
            unique case (in_data.scheme)
                cmap_pkg::SCHEME_GRAY:
                begin
                    data_next.r = t;
                    data_next.g = t;
                    data_next.b = t;
                end
                cmap_pkg::SCHEME_HOT:
                begin
                    if (seg3 == 2'd0)
                    begin
                        data_next.r = f3;
                    end
                    else if (seg3 == 2'd1)
                    begin
                        data_next.r = cmap_pkg::LEVEL_ONE;
                        data_next.g = f3;
                    end
                    else
                    begin
                        data_next.r = cmap_pkg::LEVEL_ONE;
                        data_next.g = cmap_pkg::LEVEL_ONE;
                        data_next.b = f3;
                    end
                end
                cmap_pkg::SCHEME_JET:
                begin
                    unique case (seg4)
                        2'd0:
                        begin
                            data_next.b = jet_low;
                        end
                        2'd1:
                        begin
                            data_next.g = f4;
                            data_next.b = cmap_pkg::LEVEL_ONE;
                        end
                        2'd2:
                        begin
                            data_next.r = f4;
                            data_next.g = cmap_pkg::LEVEL_ONE;
                            data_next.b = inv_f4;
                        end
                        default:
                        begin
                            data_next.r = cmap_pkg::LEVEL_ONE;
                            data_next.g = inv_f4;
                        end
                    endcase
                end
                cmap_pkg::SCHEME_COLD:
                begin
                    if (seg3 == 2'd0)
                    begin
                        data_next.b = f3;
                    end
                    else if (seg3 == 2'd1)
                    begin
                        data_next.g = f3;
                        data_next.b = cmap_pkg::LEVEL_ONE;
                    end
                    else
                    begin
                        data_next.r = f3;
                        data_next.g = cmap_pkg::LEVEL_ONE;
                        data_next.b = cmap_pkg::LEVEL_ONE;
                    end
                end
                cmap_pkg::SCHEME_BLUE:
                begin
                    data_next.b = t;
                end
                cmap_pkg::SCHEME_CYCLIC:
                begin
                    if (seg3 == 2'd0)
                    begin
                        data_next.r = inv_f3;
                        data_next.b = f3;
                    end
                    else if (seg3 == 2'd1)
                    begin
                        data_next.g = f3;
                        data_next.b = inv_f3;
                    end
                    else
                    begin
                        data_next.r = f3;
                        data_next.g = inv_f3;
                    end
                end
                cmap_pkg::SCHEME_SIGNED:
                begin
                    data_next.r = in_data.s_pos ? signed_r : 17'd0;
                    data_next.g = t;
                    data_next.b = signed_b;
                end
                default:
                begin
                    data_next.r = 17'd0;
                end
            endcase
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* sv/scalar_to_rgb_colormap.sv */
// Scalar to RGB color map.
// Input channel: in_valid/in_ready carry one signed Q16.16 sample_value per item.
// Output channel: out_valid/out_ready carry red, green and blue, 8 bits each,
// 255 standing for 1.0, exactly one output item per input item, in order.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// selects the scheme, 1 and 2 the range bounds, 3 to 5 the reciprocals that
// software computes. cfg_ready is always high; write only while no item is in
// flight.
// Range checks, a 32 by 32 multiply, position clamp, color curve and channel
// scaling each take one register stage. Throughput is one item per cycle
// while the receiver does not stall.
// Each stage holds its own valid bit and loads whenever it is empty or drains,
// so when the receiver stalls, items close up behind the output register and
// in_ready drops only once every stage holds an item.
// Reset empties the pipeline and loads the scheme gray, range 0 to 1.0 and
// unit reciprocals.
`default_nettype none

module scalar_to_rgb_colormap (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] sample_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    cmap_pkg::cfg_t    cfg_reg;
    cmap_pkg::front_t  front_data;
    cmap_pkg::prod_t   prod_data;
    cmap_pkg::norm_t   norm_data;
    cmap_pkg::level_t  level_data;
    logic              front_valid;
    logic              front_ready;
    logic              prod_valid;
    logic              prod_ready;
    logic              norm_valid;
    logic              norm_ready;
    logic              level_valid;
    logic              level_ready;
    logic              out_valid_reg;
    logic [7:0]        red_reg;
    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scheme       <= cmap_pkg::SCHEME_GRAY;
            cfg_reg.low_bound    <= cmap_pkg::RESET_LOW;
            cfg_reg.high_bound   <= cmap_pkg::RESET_HIGH;
            cfg_reg.inv_span     <= cmap_pkg::RESET_INV;
            cfg_reg.inv_positive <= cmap_pkg::RESET_INV;
            cfg_reg.inv_negative <= cmap_pkg::RESET_INV;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cmap_pkg::REG_SCHEME:   cfg_reg.scheme       <= cfg_data[2:0];
                cmap_pkg::REG_LOW:      cfg_reg.low_bound    <= cfg_data;
                cmap_pkg::REG_HIGH:     cfg_reg.high_bound   <= cfg_data;
                cmap_pkg::REG_INV_SPAN: cfg_reg.inv_span     <= cfg_data;
                cmap_pkg::REG_INV_POS:  cfg_reg.inv_positive <= cfg_data;
                cmap_pkg::REG_INV_NEG:  cfg_reg.inv_negative <= cfg_data;
                default:                cfg_reg.scheme       <= cfg_reg.scheme;
            endcase
        end
    end

    // Pipeline stages.
    cmap_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .cfg          (cfg_reg),
        .out_valid    (front_valid),
        .out_ready    (front_ready),
        .out_data     (front_data)
    );

    cmap_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    cmap_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    cmap_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (level_valid),
        .out_ready (level_ready),
        .out_data  (level_data)
    );

    // Output register: scale the levels to 8-bit channels.
    assign level_ready = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (level_ready)
        begin
            out_valid_reg <= level_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (level_ready && level_valid)
        begin
            red_reg   <= cmap_pkg::chan_scale(level_data.r);
            green_reg <= cmap_pkg::chan_scale(level_data.g);
            blue_reg  <= cmap_pkg::chan_scale(level_data.b);
        end
    end

    // An empty output register means every stage can take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while output register is empty");

    // An accepted item occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> front_valid)
        else $error("accepted item did not reach the first stage");

    // Color levels never exceed 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        level_valid |-> (level_data.r <= cmap_pkg::LEVEL_ONE)
                        && (level_data.g <= cmap_pkg::LEVEL_ONE)
                        && (level_data.b <= cmap_pkg::LEVEL_ONE))
        else $error("color level above full scale");

endmodule

`default_nettype wire

/* bench/scalar_to_rgb_colormap_test.sv */
`timescale 1ns / 1ps

module scalar_to_rgb_colormap_test;

    localparam int     RESET_CYCLES  = 9;
    localparam int     DRAIN_CYCLES  = 10;
    localparam int     IDLE_PERCENT  = 30;
    localparam int     REPORT_LIMIT  = 10;
    localparam int     RANDOM_PHASES = 22;
    localparam int     STEADY_ITEMS  = 300;
    localparam longint RUN_LIMIT_NS  = 4000000;

    // Spare register indexes that the block must ignore.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // Q.16 levels and curve constants.
    localparam logic [63:0] LVL_ONE       = 64'd65536;
    localparam logic [63:0] LVL_HALF      = 64'd32768;
    localparam logic [63:0] LVL_075       = 64'd49152;
    localparam logic [63:0] JET_FLOOR     = 64'd35389;
    localparam logic [63:0] JET_RISE      = 64'd30147;
    localparam logic [63:0] WRAP_MASK     = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] FRACTION_MASK = 64'hFFFF;

    localparam longint      Q40_ONE    = 64'sd1099511627776;
    localparam longint      MIN_SAMPLE = -64'sd2147483648;
    localparam longint      MAX_SAMPLE = 64'sd2147483647;
    localparam longint      TWO_UNITS  = 64'sd131072;
    localparam logic [31:0] UNIT_RECIP = 32'd16777216;

    typedef enum int {
        RANGE_FULL,
        RANGE_JUNK_RECIP,
        RANGE_INVERTED,
        RANGE_NARROW,
        RANGE_TYPICAL
    } range_kind_e;

    typedef struct packed {
        logic [31:0] sample;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } color_entry_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [31:0] sample_value = 32'd0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index    = 3'd0;
    logic [31:0] cfg_data     = 32'd0;

    cmap_pkg::cfg_t shadow_cfg;
    color_entry_t   expected_colors[$];
    int             failure_count = 0;
    logic           steady_flow   = 1'b0;

    scalar_to_rgb_colormap u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 125 MHz clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Scale a Q.16 level to a rounded 8-bit channel, clamping above 1.0.
    function automatic logic [7:0] level_to_byte(input logic [63:0] level);
        logic [63:0] x;
        logic [63:0] scaled;
        x      = (level > LVL_ONE) ? LVL_ONE : level;
        scaled = (x * 64'd255 + LVL_HALF) >> 16;
        return scaled[7:0];
    endfunction

    function automatic logic [23:0] to_rgb(input logic [63:0] r, input logic [63:0] g,
                                           input logic [63:0] b);
        return {level_to_byte(r), level_to_byte(g), level_to_byte(b)};
    endfunction

    // Normalized position (v * recip) >> 24, capped.
    function automatic logic [63:0] position(input logic [63:0] v, input logic [31:0] recip,
                                             input logic [63:0] cap);
        logic [63:0] p;
        p = (v * {32'd0, recip}) >> 24;
        return (p > cap) ? cap : p;
    endfunction

    // Expected color of one sample under the current register settings.
    function automatic color_entry_t predict_color(input logic [31:0] sample);
        longint       s;
        longint       lo;
        longint       hi;
        longint       v;
        logic [63:0]  t;
        logic [63:0]  w;
        logic [63:0]  seg;
        logic [63:0]  f;
        logic [63:0]  fill;
        logic [63:0]  wrapped;
        logic [23:0]  rgb;
        color_entry_t e;
        s  = $signed(sample);
        lo = $signed(shadow_cfg.low_bound);
        hi = $signed(shadow_cfg.high_bound);
        v  = s - lo;
        if (shadow_cfg.scheme == cmap_pkg::SCHEME_BLACK)
            rgb = to_rgb(0, 0, 0);
        else if (shadow_cfg.scheme == cmap_pkg::SCHEME_SIGNED)
        begin
            // Positive side runs red to white, negative side black to cyan.
            if (s > 0)
            begin
                if (s > hi)
                    rgb = to_rgb(LVL_ONE, LVL_ONE, LVL_ONE);
                else
                begin
                    t    = position(s, shadow_cfg.inv_positive, LVL_ONE);
                    fill = (t > LVL_HALF) ? 2 * t - LVL_ONE : 64'd0;
                    rgb  = to_rgb(LVL_075 + (t >> 2), t, fill);
                end
            end
            else if (s < lo)
                rgb = to_rgb(0, 0, 0);
            else
            begin
                t    = position(v, shadow_cfg.inv_negative, LVL_ONE);
                fill = (t > LVL_HALF) ? 2 * t - LVL_ONE : 64'd0;
                rgb  = to_rgb(0, t, fill);
            end
        end
        else if (shadow_cfg.scheme == cmap_pkg::SCHEME_CYCLIC)
        begin
            // The fractional position wraps, also below the low bound.
            wrapped = v;
            wrapped = (wrapped * {32'd0, shadow_cfg.inv_span}) & WRAP_MASK;
            w       = 3 * (wrapped >> 24);
            seg     = w >> 16;
            f       = w & FRACTION_MASK;
            if (seg == 0)
                rgb = to_rgb(LVL_ONE - f, 0, f);
            else if (seg == 1)
                rgb = to_rgb(0, f, LVL_ONE - f);
            else
                rgb = to_rgb(f, LVL_ONE - f, 0);
        end
        else if (v < 0)
            rgb = to_rgb(0, 0, 0);
        else if (s >= hi)
        begin
            if (shadow_cfg.scheme == cmap_pkg::SCHEME_JET)
                rgb = to_rgb(LVL_ONE, 0, 0);
            else if (shadow_cfg.scheme == cmap_pkg::SCHEME_BLUE)
                rgb = to_rgb(0, 0, LVL_ONE);
            else
                rgb = to_rgb(LVL_ONE, LVL_ONE, LVL_ONE);
        end
        else
        begin
            // Inside the range the position stays just under 1.0.
            t = position(v, shadow_cfg.inv_span, LVL_ONE - 1);
            case (shadow_cfg.scheme)
                cmap_pkg::SCHEME_GRAY:
                    rgb = to_rgb(t, t, t);
                cmap_pkg::SCHEME_HOT:
                begin
                    w   = 3 * t;
                    seg = w >> 16;
                    f   = w & FRACTION_MASK;
                    if (seg == 0)
                        rgb = to_rgb(f, 0, 0);
                    else if (seg == 1)
                        rgb = to_rgb(LVL_ONE, f, 0);
                    else
                        rgb = to_rgb(LVL_ONE, LVL_ONE, f);
                end
                cmap_pkg::SCHEME_JET:
                begin
                    w   = 4 * t;
                    seg = w >> 16;
                    f   = w & FRACTION_MASK;
                    if (seg == 0)
                        rgb = to_rgb(0, 0, JET_FLOOR + ((JET_RISE * f + LVL_HALF) >> 16));
                    else if (seg == 1)
                        rgb = to_rgb(0, f, LVL_ONE);
                    else if (seg == 2)
                        rgb = to_rgb(f, LVL_ONE, LVL_ONE - f);
                    else
                        rgb = to_rgb(LVL_ONE, LVL_ONE - f, 0);
                end
                cmap_pkg::SCHEME_COLD:
                begin
                    w   = 3 * t;
                    seg = w >> 16;
                    f   = w & FRACTION_MASK;
                    if (seg == 0)
                        rgb = to_rgb(0, 0, f);
                    else if (seg == 1)
                        rgb = to_rgb(0, f, LVL_ONE);
                    else
                        rgb = to_rgb(f, LVL_ONE, LVL_ONE);
                end
                default:
                    rgb = to_rgb(0, 0, t);
            endcase
        end
        e.sample = sample;
        {e.red, e.green, e.blue} = rgb;
        return e;
    endfunction

    // Reciprocal in Q8.24 of a Q16.16 distance, saturated; zero when not positive.
    function automatic logic [31:0] reciprocal_q824(input longint span);
        longint q;
        if (span <= 0)
            return 32'd0;
        q = Q40_ONE / span;
        return (q > 64'sd4294967295) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [31:0] odd_recip();
        case ($urandom_range(0, 2))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Samples mostly around the configured range, some at its edges, some anywhere.
    function automatic logic [31:0] pick_sample(input longint lo, input longint hi);
        longint a;
        longint b;
        longint margin;
        longint span_w;
        longint picked;
        int     roll;
        roll = $urandom_range(0, 99);
        a    = (lo < hi) ? lo : hi;
        b    = (lo < hi) ? hi : lo;
        if (roll < 10)
            return $urandom;
        if (roll < 25)
        begin
            case ($urandom_range(0, 8))
                0:       picked = lo;
                1:       picked = lo + 1;
                2:       picked = lo - 1;
                3:       picked = hi;
                4:       picked = hi - 1;
                5:       picked = hi + 1;
                6:       picked = 0;
                7:       picked = -1;
                default: picked = 1;
            endcase
            return picked[31:0];
        end
        margin = (b - a) / 4 + 1;
        span_w = b - a + 2 * margin + 1;
        picked = a - margin + {$urandom, $urandom} % span_w;
        if (picked < MIN_SAMPLE)
            picked = MIN_SAMPLE;
        if (picked > MAX_SAMPLE)
            picked = MAX_SAMPLE;
        return picked[31:0];
    endfunction

    task automatic note_failure(input string detail);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
            $display("mismatch: %s", detail);
    endtask

    // Offer one sample, with random idle cycles ahead of it unless the steady stretch is running, and record its color.
    task automatic send_sample(input logic [31:0] value);
        if (!steady_flow)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        sample_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_colors = {expected_colors, predict_color(value)};
    endtask

    // Stop offering items and wait until every expected color has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] reg_index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (reg_index)
            cmap_pkg::REG_SCHEME:   shadow_cfg.scheme       = data[2:0];
            cmap_pkg::REG_LOW:      shadow_cfg.low_bound    = data;
            cmap_pkg::REG_HIGH:     shadow_cfg.high_bound   = data;
            cmap_pkg::REG_INV_SPAN: shadow_cfg.inv_span     = data;
            cmap_pkg::REG_INV_POS:  shadow_cfg.inv_positive = data;
            cmap_pkg::REG_INV_NEG:  shadow_cfg.inv_negative = data;
            default:                ;
        endcase
    endtask

    // Rewrite every register once the block has drained. Items always follow.
    task automatic apply_config(input logic [2:0] scheme, input logic [31:0] low,
                                input logic [31:0] high, input logic [31:0] span_recip,
                                input logic [31:0] pos_recip, input logic [31:0] neg_recip);
        settle();
        write_reg(cmap_pkg::REG_SCHEME, ($urandom & 32'hFFFF_FFF8) | {29'd0, scheme});
        write_reg(cmap_pkg::REG_LOW, low);
        write_reg(cmap_pkg::REG_HIGH, high);
        write_reg(cmap_pkg::REG_INV_SPAN, span_recip);
        write_reg(cmap_pkg::REG_INV_POS, pos_recip);
        write_reg(cmap_pkg::REG_INV_NEG, neg_recip);
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic use_range(input logic [2:0] scheme, input longint low, input longint high);
        apply_config(scheme, low[31:0], high[31:0], reciprocal_q824(high - low),
                     reciprocal_q824(high), reciprocal_q824(-low));
    endtask

    task automatic test_reset_defaults();
        // Gray over 0 to 1.0 straight out of reset.
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_FFFF);
        send_sample(32'h0001_0000);
        send_sample(32'h7FFF_FFFF);
    endtask

    task automatic test_scheme_curves();
        use_range(cmap_pkg::SCHEME_HOT, -TWO_UNITS, TWO_UNITS);
        send_sample(32'd0);
        // Jet turns red from the high bound up.
        use_range(cmap_pkg::SCHEME_JET, -TWO_UNITS, TWO_UNITS);
        send_sample(TWO_UNITS[31:0]);
        send_sample(-32'sd100000);
        use_range(cmap_pkg::SCHEME_COLD, -TWO_UNITS, TWO_UNITS);
        send_sample(32'd40000);
        // Blue saturates to full blue above the range.
        use_range(cmap_pkg::SCHEME_BLUE, -TWO_UNITS, TWO_UNITS);
        send_sample(TWO_UNITS[31:0] + 32'd5);
        send_sample(-32'sd65536);
        use_range(cmap_pkg::SCHEME_BLACK, -TWO_UNITS, TWO_UNITS);
        send_sample(32'd12345);
    endtask

    task automatic test_cyclic_wrap();
        // Positions wrap relative to the low bound on both sides of the range.
        use_range(cmap_pkg::SCHEME_CYCLIC, -TWO_UNITS, TWO_UNITS);
        send_sample(-32'sd231072);
        send_sample(32'd201072);
    endtask

    task automatic test_signed_map();
        use_range(cmap_pkg::SCHEME_SIGNED, -TWO_UNITS, TWO_UNITS);
        send_sample(32'd50000);
        send_sample(TWO_UNITS[31:0] + 32'd1);
        send_sample(-32'sd50000);
        send_sample(-32'sd131073);
    endtask

    task automatic test_misconfigured();
        // A zero reciprocal pins the position at zero.
        apply_config(cmap_pkg::SCHEME_GRAY, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0);
        send_sample(32'd30000);
        // With low above high the below-range test wins.
        apply_config(cmap_pkg::SCHEME_HOT, 32'd65536, 32'd0, UNIT_RECIP, UNIT_RECIP,
                     UNIT_RECIP);
        send_sample(32'd32768);
        send_sample(32'd100000);
    endtask

    task automatic test_steady_stream();
        longint lo;
        longint hi;
        lo = $urandom_range(0, 32'h0200_0000);
        lo = lo - 16777216;
        hi = lo + $urandom_range(1024, 32'h0400_0000);
        use_range(cmap_pkg::SCHEME_JET, lo, hi);
        // Both sides run without a single idle cycle.
        steady_flow = 1'b1;
        repeat (STEADY_ITEMS)
            send_sample(pick_sample(lo, hi));
        steady_flow = 1'b0;
    endtask

    task automatic test_random_ranges();
        longint      lo;
        longint      hi;
        logic [2:0]  scheme;
        range_kind_e kind;
        int          roll;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            scheme = 3'($urandom_range(cmap_pkg::SCHEME_GRAY, cmap_pkg::SCHEME_BLACK));
            roll   = (phase < 4) ? phase : $urandom_range(0, 9);
            kind   = range_kind_e'((roll < 4) ? roll : 4);
            lo     = $urandom_range(0, 32'h0200_0000);
            lo     = lo - 16777216;
            case (kind)
                RANGE_FULL:
                begin
                    lo = MIN_SAMPLE;
                    hi = MAX_SAMPLE;
                    use_range(scheme, lo, hi);
                end
                RANGE_JUNK_RECIP:
                begin
                    lo = $signed($urandom);
                    hi = $signed($urandom);
                    apply_config(scheme, lo[31:0], hi[31:0], odd_recip(), odd_recip(),
                                 odd_recip());
                end
                RANGE_INVERTED:
                begin
                    hi = lo - $urandom_range(1, 32'h0010_0000);
                    apply_config(scheme, lo[31:0], hi[31:0], reciprocal_q824(lo - hi),
                                 reciprocal_q824(hi), reciprocal_q824(-lo));
                end
                RANGE_NARROW:
                begin
                    hi = lo + $urandom_range(1, 600);
                    use_range(scheme, lo, hi);
                end
                default:
                begin
                    hi = lo + $urandom_range(1024, 32'h0400_0000);
                    use_range(scheme, lo, hi);
                end
            endcase
            repeat ($urandom_range(40, 90))
                send_sample(pick_sample(lo, hi));
        end
    endtask

    // Receiver stalls at random unless the steady stretch is running.
    always @(posedge clk)
        out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Compare each output item with the oldest expected color.
    always @(posedge clk)
    begin : check_results
        color_entry_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_colors.size() == 0)
                note_failure($sformatf("output item %02h %02h %02h with nothing expected",
                                       red, green, blue));
            else
            begin
                want = expected_colors.pop_front();
                if (red !== want.red || green !== want.green || blue !== want.blue)
                    note_failure($sformatf(
                        "sample %08h expected rgb %02h %02h %02h, got %02h %02h %02h",
                        want.sample, want.red, want.green, want.blue, red, green, blue));
            end
        end
    end

    initial
    begin
        shadow_cfg.scheme       = cmap_pkg::SCHEME_GRAY;
        shadow_cfg.low_bound    = 32'd0;
        shadow_cfg.high_bound   = 32'd65536;
        shadow_cfg.inv_span     = UNIT_RECIP;
        shadow_cfg.inv_positive = UNIT_RECIP;
        shadow_cfg.inv_negative = UNIT_RECIP;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_scheme_curves();
        test_cyclic_wrap();
        test_signed_map();
        test_misconfigured();
        test_steady_stream();
        test_random_ranges();
        settle();
        // Give a stray extra output item time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failure_count == 0 && expected_colors.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop for a hung handshake.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
sv/cmap_pkg.sv
sv/cmap_front.sv
sv/cmap_mult.sv
sv/cmap_norm.sv
sv/cmap_level.sv
sv/scalar_to_rgb_colormap.sv
bench/scalar_to_rgb_colormap_test.sv
